// File: src/smcs_pkg.sv
package smcs_pkg;

    // Sample format and fixed constants.
    localparam int SAMPLE_W      = 24;
    localparam int FRAC_BITS     = SAMPLE_W - 4;
    localparam int LOG_DEPTH_DEF = 256;
    localparam int LOG_DEPTH_MAX = 4096;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [23:0] ENV_ONE = 24'h800000;
    localparam logic [15:0] SHAPE_K = 16'd1966;

    // Reset values of the configuration registers.
    localparam logic [2:0]  MODE_RESET    = 3'd0;
    localparam logic [23:0] ATTACK_RESET  = 24'd34914;
    localparam logic [23:0] RELEASE_RESET = 24'd2912;
    localparam logic        STEREO_RESET  = 1'b1;

    // Mode codes.
    localparam logic [2:0] MODE_OFF     = 3'd0;
    localparam logic [2:0] MODE_PRESET1 = 3'd1;
    localparam logic [2:0] MODE_PRESET4 = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_ATTACK  = 2'd1;
    localparam logic [1:0] CFG_RELEASE = 2'd2;
    localparam logic [1:0] CFG_STEREO  = 2'd3;

    // Preset tables: threshold magnitude in log2 Q.16, slope Q0.16, makeup Q1.22.
    localparam logic [17:0] THR_LOG [4] = '{18'd174165, 18'd195935, 18'd217706, 18'd261247};
    localparam logic [15:0] SLOPE   [4] = '{16'd49152, 16'd57344, 16'd60075, 16'd62259};
    localparam logic [22:0] MAKEUP  [4] = '{23'd4984940, 23'd5924612, 23'd7041414,
                                           23'd8368737};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_in;
        logic signed [SAMPLE_W-1:0] right_in;
        logic                       block_last;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       block_last_out;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  comp_mode;
        logic [23:0] attack_coeff;
        logic [23:0] release_coeff;
        logic        stereo_enable;
    } cfg_t;

    // Classified request as it travels from the front end to the back end.
    typedef struct packed {
        logic                       bypass;
        logic [1:0]                 sel;
        logic                       peak_zero;
        logic [4:0]                 peak_exp;
        logic [22:0]                peak_frac;
        logic signed [SAMPLE_W-1:0] left_s;
        logic signed [SAMPLE_W-1:0] right_s;
        logic                       last;
    } qitem_t;

    typedef logic [16:0] log_arr_t [0:LOG_DEPTH_MAX];
    typedef logic [30:0] exp_arr_t [0:LOG_DEPTH_MAX];

    // Truncating Q1.30 power by square and multiply.
    function automatic logic [63:0] qpow(input logic [63:0] base_in, input int k_in);
        logic [63:0] acc;
        logic [63:0] base;
        int          k;
        acc  = 64'd1 << 30;
        base = base_in;
        k    = k_in;
        while (k != 0) begin
            if ((k & 1) != 0)
                acc = (acc * base) >> 30;
            base = (base * base) >> 30;
            k = k >> 1;
        end
        return acc;
    endfunction

    // log2(1+i/depth) in Q0.16, built by repeated squaring.
    function automatic log_arr_t build_log_tab(input int depth);
        log_arr_t    tab;
        logic [63:0] x;
        logic [16:0] v;
        int          sh;
        tab = '{default: '0};
        sh  = $clog2(depth);
        for (int i = 0; i < depth; i++) begin
            x = (64'(depth + i) << 30) >> sh;
            v = '0;
            for (int b = 0; b < 16; b++) begin
                x = (x * x) >> 30;
                v = {v[15:0], 1'b0};
                if (x >= (64'd1 << 31)) begin
                    v[0] = 1'b1;
                    x = x >> 1;
                end
            end
            tab[i] = v;
        end
        tab[depth] = 17'd65536;
        return tab;
    endfunction

    // 2^(-i/depth) in Q1.30, stepped by the largest ratio whose power stays at or above 0.5.
    function automatic exp_arr_t build_exp_tab(input int depth);
        exp_arr_t    tab;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        tab = '{default: '0};
        lo  = 64'd1 << 29;
        hi  = 64'd1 << 30;
        while (lo < hi) begin
            mid = lo + ((hi - lo + 64'd1) >> 1);
            if (qpow(mid, depth) >= (64'd1 << 29))
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        tab[0] = 31'd1 << 30;
        for (int i = 1; i <= depth; i++)
            tab[i] = 31'((64'(tab[i-1]) * lo) >> 30);
        tab[depth] = 31'd1 << 29;
        return tab;
    endfunction

endpackage

// File: src/stereo_mode_compressor_saturator_core.sv
// Stereo peak compressor with soft saturation.
// The sample channel (sample_valid, sample_stall, sample_data) takes one stereo
// request per pair; a request is taken when valid is high and stall is low.
// The result channel (result_valid, result_stall, result_data) returns exactly one
// result per request, in order; the receiver holds result_stall to pause it.
// The cfg channel writes register cfg_index with cfg_data whenever cfg_valid is
// high; cfg_ready is always high. Write it only while the block is idle.
// A pair above threshold runs every sequencer step; a pair at or below threshold
// (silence included) skips the exp lookup and interpolation steps, and a bypassed
// pair goes straight to the shape step. The back-end sequencer does at most one multiply
// per channel in each step and takes no new pair until the last has left its shape step.
// A two-entry queue sits between the front end and the sequencer, so up to two
// further requests are taken while the sequencer works or while the result
// register waits under stall. When the queue is full, sample_stall rises.
// Reset empties the queue, drops the result valid, loads the configuration reset
// values, and sets the gain envelope to unity.
module stereo_mode_compressor_saturator_core #(
    parameter int LOG_TABLE_DEPTH = smcs_pkg::LOG_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  smcs_pkg::in_item_t  sample_data,
    output logic                result_valid,
    input  logic                result_stall,
    output smcs_pkg::out_item_t result_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [23:0]         cfg_data
);

    smcs_pkg::cfg_t   cfg_reg, cfg_next;
    smcs_pkg::qitem_t front_item;
    smcs_pkg::qitem_t q_head;
    logic             q_full;
    logic             q_not_empty;
    logic             q_pop;
    logic             push;
    logic [2:0]       in_flight_reg, in_flight_next;

    assign cfg_ready    = 1'b1;
    assign sample_stall = q_full;
    assign push         = sample_valid && !q_full;

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                smcs_pkg::CFG_MODE:    cfg_next.comp_mode     = cfg_data[2:0];
                smcs_pkg::CFG_ATTACK:  cfg_next.attack_coeff  = cfg_data;
                smcs_pkg::CFG_RELEASE: cfg_next.release_coeff = cfg_data;
                smcs_pkg::CFG_STEREO:  cfg_next.stereo_enable = cfg_data[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    // Count of requests whose results are not yet delivered.
    always_comb
    begin
        in_flight_next = in_flight_reg;
        if (push && !(result_valid && !result_stall))
            in_flight_next = in_flight_reg + 3'd1;
        else if (!push && result_valid && !result_stall)
            in_flight_next = in_flight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.comp_mode     <= smcs_pkg::MODE_RESET;
            cfg_reg.attack_coeff  <= smcs_pkg::ATTACK_RESET;
            cfg_reg.release_coeff <= smcs_pkg::RELEASE_RESET;
            cfg_reg.stereo_enable <= smcs_pkg::STEREO_RESET;
            in_flight_reg         <= '0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_flight_reg <= in_flight_next;
        end
    end

    smcs_front u_front (
        .sample_data (sample_data),
        .cfg         (cfg_reg),
        .item        (front_item)
    );

    smcs_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    smcs_back #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    // No result appears without an outstanding request.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> in_flight_reg != 3'd0)
        else $error("result without outstanding request");

    // Queue, sequencer and result register bound the outstanding requests.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        in_flight_reg <= 3'(smcs_pkg::QUEUE_DEPTH + 2))
        else $error("too many outstanding requests");

    // The sequencer only takes from a queue that holds something.
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("pop from empty queue");

endmodule

// File: src/smcs_front.sv
module smcs_front (
    input  smcs_pkg::in_item_t sample_data,
    input  smcs_pkg::cfg_t     cfg,
    output smcs_pkg::qitem_t   item
);

    logic signed [23:0] right_v;
    logic [23:0]        mag_l;
    logic [23:0]        mag_r;
    logic [23:0]        peak;
    logic [4:0]         msb;
    logic [23:0]        shifted;

    // Mono mode drops the right sample before anything else sees it.
    assign right_v = cfg.stereo_enable ? sample_data.right_in : 24'sd0;
    assign mag_l   = sample_data.left_in[23] ? 24'(~sample_data.left_in + 24'sd1)
                                             : 24'(sample_data.left_in);
    assign mag_r   = right_v[23] ? 24'(~right_v + 24'sd1) : 24'(right_v);
    assign peak    = (mag_r > mag_l) ? mag_r : mag_l;

    // Position of the leading one of the peak.
    always_comb
    begin
        msb = '0;
        for (int k = 0; k < 24; k++)
            if (peak[k])
                msb = 5'(k);
    end

    assign shifted = peak << (5'd23 - msb);

    // Classify the request for the back end.
    always_comb
    begin
        item.bypass    = (cfg.comp_mode == smcs_pkg::MODE_OFF);
        item.sel       = 2'd0;
        if (cfg.comp_mode >= smcs_pkg::MODE_PRESET1 && cfg.comp_mode <= smcs_pkg::MODE_PRESET4)
            item.sel = 2'(cfg.comp_mode - smcs_pkg::MODE_PRESET1);
        item.peak_zero = (peak == '0);
        item.peak_exp  = msb;
        item.peak_frac = shifted[22:0];
        item.left_s    = sample_data.left_in;
        item.right_s   = right_v;
        item.last      = sample_data.block_last;
    end

endmodule

// File: src/smcs_queue.sv
module smcs_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  smcs_pkg::qitem_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output smcs_pkg::qitem_t head
);

    localparam int PW = (smcs_pkg::QUEUE_DEPTH > 1) ? $clog2(smcs_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(smcs_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(smcs_pkg::QUEUE_DEPTH - 1);

    smcs_pkg::qitem_t entry_reg [smcs_pkg::QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full      = (count_reg == CW'(smcs_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: src/smcs_back.sv
module smcs_back #(
    parameter int LOG_TABLE_DEPTH = smcs_pkg::LOG_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  smcs_pkg::cfg_t      cfg,
    input  logic                q_not_empty,
    input  smcs_pkg::qitem_t    q_head,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_stall,
    output smcs_pkg::out_item_t result_data
);

    localparam int DB = $clog2(LOG_TABLE_DEPTH);
    localparam int IW = $clog2(LOG_TABLE_DEPTH + 1);
    localparam smcs_pkg::log_arr_t LOG_TAB = smcs_pkg::build_log_tab(LOG_TABLE_DEPTH);
    localparam smcs_pkg::exp_arr_t EXP_TAB = smcs_pkg::build_exp_tab(LOG_TABLE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_LOGA, S_LOGM, S_GAIN, S_EXPA, S_EXPM,
        S_ENV, S_TOTAL, S_SCALE, S_SQUARE, S_SHAPE
    } state_t;

    state_t              state_reg, state_next;
    smcs_pkg::qitem_t    item_reg, item_next;
    logic [16:0]         la_reg, la_next;
    logic [16:0]         ld_reg, ld_next;
    logic                lneg_reg, lneg_next;
    logic [22:0]         lrem_reg, lrem_next;
    logic [24:0]         over_reg, over_next;
    logic [23:0]         gr_reg, gr_next;
    logic [30:0]         ea_reg, ea_next;
    logic [30:0]         ed_reg, ed_next;
    logic                eneg_reg, eneg_next;
    logic [15:0]         erem_reg, erem_next;
    logic [23:0]         target_reg, target_next;
    logic [23:0]         env_reg, env_next;
    logic [24:0]         total_reg, total_next;
    logic [25:0]         ml_reg, ml_next;
    logic [25:0]         mr_reg, mr_next;
    logic [31:0]         sql_reg, sql_next;
    logic [31:0]         sqr_reg, sqr_next;
    logic                out_valid_reg, out_valid_next;
    smcs_pkg::out_item_t out_data_reg, out_data_next;

    logic [DB+22:0] lpos;
    logic [DB+15:0] epos;
    logic [IW-1:0]  lidx;
    logic [IW-1:0]  eidx;
    logic [16:0]    lta, ltb;
    logic [30:0]    eta, etb;
    logic [39:0]    lprod;
    logic [24:0]    lval;
    logic [6:0]     ex;
    logic [24:0]    over_v;
    logic [39:0]    grprod;
    logic [46:0]    eprod;
    logic [32:0]    ev;
    logic [8:0]     esh;
    logic [31:0]    eshifted;
    logic           lower;
    logic [23:0]    ediff;
    logic [23:0]    ecoef;
    logic [47:0]    envprod;
    logic [46:0]    totprod;
    logic [23:0]    mag_l, mag_r;
    logic [48:0]    scl_l, scl_r;
    logic [51:0]    sq_l, sq_r;
    logic [42:0]    h_l, h_r;
    logic [27:0]    s_l, s_r;
    logic           out_free;

    // Saturate a shaped magnitude after restoring the sign.
    function automatic logic [23:0] finish(input logic [27:0] s, input logic neg);
        logic [27:0] v;
        v = neg ? 28'(-s) : s;
        if ($signed(v) > 28'sd8388607)
            return 24'h7FFFFF;
        else if ($signed(v) < -28'sd8388608)
            return 24'h800000;
        return v[23:0];
    endfunction

    // Table positions: index and interpolation weight.
    assign lpos = {item_reg.peak_frac, {DB{1'b0}}};
    assign lidx = IW'(lpos[DB+22:23]);
    assign epos = {gr_reg[15:0], {DB{1'b0}}};
    assign eidx = IW'(epos[DB+15:16]);
    assign lta  = LOG_TAB[lidx];
    assign ltb  = LOG_TAB[lidx + IW'(1)];
    assign eta  = EXP_TAB[eidx];
    assign etb  = EXP_TAB[eidx + IW'(1)];

    // Log interpolation and amount over threshold.
    assign lprod  = 40'(ld_reg) * 40'(lrem_reg);
    assign lval   = lneg_reg ? 25'(la_reg) - 25'(lprod[39:23]) : 25'(la_reg) + 25'(lprod[39:23]);
    assign ex     = 7'(item_reg.peak_exp) - 7'd20;
    assign over_v = {{2{ex[6]}}, ex, 16'b0} + lval + 25'(smcs_pkg::THR_LOG[item_reg.sel]);

    // Gain reduction and its power of two.
    assign grprod   = 40'(over_reg[23:0]) * 40'(smcs_pkg::SLOPE[item_reg.sel]);
    assign eprod    = 47'(ed_reg) * 47'(erem_reg);
    assign ev       = eneg_reg ? 33'(ea_reg) - 33'(eprod[46:16]) : 33'(ea_reg) + 33'(eprod[46:16]);
    assign esh      = 9'(gr_reg[23:16]) + 9'd7;
    assign eshifted = ev[31:0] >> esh;

    // Envelope smoothing.
    assign lower   = target_reg < env_reg;
    assign ediff   = lower ? env_reg - target_reg : target_reg - env_reg;
    assign ecoef   = lower ? cfg.attack_coeff : cfg.release_coeff;
    assign envprod = 48'(ecoef) * 48'(ediff);
    assign totprod = 47'(env_reg) * 47'(smcs_pkg::MAKEUP[item_reg.sel]);

    // Per-channel gain and shaping lanes.
    assign mag_l = item_reg.left_s[23] ? 24'(~item_reg.left_s + 24'sd1) : 24'(item_reg.left_s);
    assign mag_r = item_reg.right_s[23] ? 24'(~item_reg.right_s + 24'sd1)
                                        : 24'(item_reg.right_s);
    assign scl_l = 49'(mag_l) * 49'(total_reg);
    assign scl_r = 49'(mag_r) * 49'(total_reg);
    assign sq_l  = 52'(ml_reg) * 52'(ml_reg);
    assign sq_r  = 52'(mr_reg) * 52'(mr_reg);
    assign h_l   = 43'(sql_reg) * 43'(smcs_pkg::SHAPE_K);
    assign h_r   = 43'(sqr_reg) * 43'(smcs_pkg::SHAPE_K);
    assign s_l   = 28'(ml_reg) - 28'(h_l[42:16]);
    assign s_r   = 28'(mr_reg) - 28'(h_r[42:16]);

    assign out_free     = !out_valid_reg || !result_stall;
    assign q_pop        = (state_reg == S_IDLE) && q_not_empty;
    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // Sequencer: each step does at most one multiply per channel.
    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        la_next        = la_reg;
        ld_next        = ld_reg;
        lneg_next      = lneg_reg;
        lrem_next      = lrem_reg;
        over_next      = over_reg;
        gr_next        = gr_reg;
        ea_next        = ea_reg;
        ed_next        = ed_reg;
        eneg_next      = eneg_reg;
        erem_next      = erem_reg;
        target_next    = target_reg;
        env_next       = env_reg;
        total_next     = total_reg;
        ml_next        = ml_reg;
        mr_next        = mr_reg;
        sql_next       = sql_reg;
        sqr_next       = sqr_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && result_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_not_empty)
                begin
                    item_next  = q_head;
                    state_next = q_head.bypass ? S_SHAPE : S_LOGA;
                end
            end
            S_LOGA:
            begin
                la_next    = lta;
                lneg_next  = ltb < lta;
                ld_next    = (ltb < lta) ? lta - ltb : ltb - lta;
                lrem_next  = lpos[22:0];
                state_next = S_LOGM;
            end
            S_LOGM:
            begin
                over_next  = over_v;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (item_reg.peak_zero || over_reg[24] || over_reg == '0)
                begin
                    target_next = smcs_pkg::ENV_ONE;
                    state_next  = S_ENV;
                end
                else
                begin
                    gr_next    = grprod[39:16];
                    state_next = S_EXPA;
                end
            end
            S_EXPA:
            begin
                ea_next    = eta;
                eneg_next  = etb < eta;
                ed_next    = (etb < eta) ? eta - etb : etb - eta;
                erem_next  = epos[15:0];
                state_next = S_EXPM;
            end
            S_EXPM:
            begin
                if (ev[32] || ev == '0 || esh >= 9'd40)
                    target_next = '0;
                else
                    target_next = eshifted[23:0];
                state_next = S_ENV;
            end
            S_ENV:
            begin
                env_next   = lower ? env_reg - envprod[47:24] : env_reg + envprod[47:24];
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                total_next = totprod[46:22];
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                ml_next    = scl_l[48:23];
                mr_next    = scl_r[48:23];
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                sql_next   = sq_l[51:20];
                sqr_next   = sq_r[51:20];
                state_next = S_SHAPE;
            end
            S_SHAPE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next.block_last_out = item_reg.last;
                    if (item_reg.bypass)
                    begin
                        out_data_next.left_out  = item_reg.left_s;
                        out_data_next.right_out = item_reg.right_s;
                    end
                    else
                    begin
                        out_data_next.left_out  = finish(s_l, item_reg.left_s[23]);
                        out_data_next.right_out = finish(s_r, item_reg.right_s[23]);
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            env_reg       <= smcs_pkg::ENV_ONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            env_reg       <= env_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working registers carry payload only.
    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        la_reg       <= la_next;
        ld_reg       <= ld_next;
        lneg_reg     <= lneg_next;
        lrem_reg     <= lrem_next;
        over_reg     <= over_next;
        gr_reg       <= gr_next;
        ea_reg       <= ea_next;
        ed_reg       <= ed_next;
        eneg_reg     <= eneg_next;
        erem_reg     <= erem_next;
        target_reg   <= target_next;
        total_reg    <= total_next;
        ml_reg       <= ml_next;
        mr_reg       <= mr_next;
        sql_reg      <= sql_next;
        sqr_reg      <= sqr_next;
        out_data_reg <= out_data_next;
    end

endmodule
